>>> src/tsrc_pkg.sv
// Shared types, opcodes and direction-aware Q40.24 helpers for the step request combiner.
package tsrc_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned InDataW  = 392;
  localparam int unsigned OutDataW = 200;
  localparam int unsigned OpW      = 2;

  localparam logic signed [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};

  typedef enum logic [OpW-1:0] {
    OP_MERGE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CHECK = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef logic signed [TimeW-1:0] time_t;

  // One request beat as unpacked from tdata
  typedef struct packed {
    logic  goal_valid;
    time_t goal_value;
    logic  size_valid;
    time_t size_value;
    logic  end_valid;
    time_t end_value;
    logic  size_limit_valid;
    time_t size_limit_value;
    logic  end_limit_valid;
    time_t end_limit_value;
    time_t start_time;
  } req_t;

  // Accumulated request state
  typedef struct packed {
    logic  goal_held;
    time_t goal_best;
    time_t size_best;
    time_t end_best;
    logic  same_source;
    time_t size_second;
    time_t end_second;
    time_t size_hard;
    time_t end_hard;
  } accum_t;

  // One result beat before packing
  typedef struct packed {
    time_t chosen_size;
    time_t chosen_end;
    logic  goal_present;
    time_t goal_out;
    logic  size_limit_violated;
    logic  end_limit_violated;
    logic  bad_request;
  } res_t;

  function automatic time_t dir_inf(input logic fwd);
    return fwd ? TimeMax : TimeMin;
  endfunction

  // "a comes before b" in the direction of evolution
  function automatic logic smaller(input logic fwd, input time_t a, input time_t b);
    return fwd ? (a < b) : (a > b);
  endfunction

  function automatic time_t pick_min(input logic fwd, input time_t a, input time_t b);
    return smaller(fwd, b, a) ? b : a;
  endfunction

  function automatic time_t pick_max(input logic fwd, input time_t a, input time_t b);
    return smaller(fwd, a, b) ? b : a;
  endfunction

  // start + x, infinity in x propagates, otherwise saturate
  function automatic time_t plus_sat(input logic fwd, input time_t start, input time_t x);
    logic [TimeW:0] sum;
    time_t          res;
    sum = {x[TimeW-1], x} + {start[TimeW-1], start};
    if (sum[TimeW] != sum[TimeW-1]) begin
      res = sum[TimeW] ? TimeMin : TimeMax;
    end else begin
      res = sum[TimeW-1:0];
    end
    return (x == dir_inf(fwd)) ? x : res;
  endfunction

  // x - start, infinity in x propagates, otherwise saturate
  function automatic time_t minus_sat(input logic fwd, input time_t x, input time_t start);
    logic [TimeW:0] dif;
    time_t          res;
    dif = {x[TimeW-1], x} - {start[TimeW-1], start};
    if (dif[TimeW] != dif[TimeW-1]) begin
      res = dif[TimeW] ? TimeMin : TimeMax;
    end else begin
      res = dif[TimeW-1:0];
    end
    return (x == dir_inf(fwd)) ? x : res;
  endfunction

  function automatic accum_t accum_clear(input logic fwd);
    accum_t a;
    a.goal_held   = 1'b0;
    a.goal_best   = '0;
    a.same_source = 1'b0;
    a.size_best   = dir_inf(fwd);
    a.end_best    = dir_inf(fwd);
    a.size_second = dir_inf(fwd);
    a.end_second  = dir_inf(fwd);
    a.size_hard   = dir_inf(fwd);
    a.end_hard    = dir_inf(fwd);
    return a;
  endfunction

endpackage

>>> src/time_step_request_combiner_top.sv
// Top level: input beat register, accumulator, result logic and output register.
// Each accepted beat passes the input register and then the output register.
// Throughput: 1 beat per cycle unless the master side stalls; state update and result
// are computed combinationally between the input register and the output register.
// Reset: asynchronous, active low; time_forward returns to 1, held times return to
// forward infinity, the goal is cleared. A config write also clears the held values.
module time_step_request_combiner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // goal_valid, goal_value, size_valid, size_value, end_valid, end_value,
  // size_limit_valid, size_limit_value, end_limit_valid, end_limit_value, start_time
  input  logic [tsrc_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic [tsrc_pkg::OpW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // chosen_size, chosen_end, goal_present, goal_out, size_limit_violated,
  // end_limit_violated, bad_request
  output logic [tsrc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);
  import tsrc_pkg::*;

  logic   in_vld_q, in_vld_d;
  op_e    in_op_q;
  req_t   in_req_q, req_in;
  logic   out_vld_q, out_vld_d;
  res_t   out_res_q, res;
  logic   fire, s_beat, fwd;
  accum_t st, st_next;

  // Unpack the slave beat
  always_comb begin
    req_in.goal_valid       = s_axis_tdata[0];
    req_in.goal_value       = s_axis_tdata[64:1];
    req_in.size_valid       = s_axis_tdata[65];
    req_in.size_value       = s_axis_tdata[129:66];
    req_in.end_valid        = s_axis_tdata[130];
    req_in.end_value        = s_axis_tdata[194:131];
    req_in.size_limit_valid = s_axis_tdata[195];
    req_in.size_limit_value = s_axis_tdata[259:196];
    req_in.end_limit_valid  = s_axis_tdata[260];
    req_in.end_limit_value  = s_axis_tdata[324:261];
    req_in.start_time       = s_axis_tdata[388:325];
  end

  // Advance when the result register is free or being drained
  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_vld_d  = s_beat ? 1'b1 : (fire ? 1'b0 : in_vld_q);
  assign out_vld_d = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  tsrc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .op_i      (in_op_q),
    .req_i     (in_req_q),
    .cfg_we_i  (cfg_valid_i),
    .cfg_fwd_i (cfg_data_i),
    .fwd_o     (fwd),
    .st_o      (st),
    .st_next_o (st_next)
  );

  tsrc_eval u_eval (
    .fwd_i     (fwd),
    .op_i      (in_op_q),
    .req_i     (in_req_q),
    .st_i      (st),
    .st_next_i (st_next),
    .res_o     (res)
  );

  // Hold control valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_op_q  <= op_e'(s_axis_tuser);
      in_req_q <= req_in;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  // Pack the master beat
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000,
                          out_res_q.bad_request,
                          out_res_q.end_limit_violated,
                          out_res_q.size_limit_violated,
                          out_res_q.goal_out,
                          out_res_q.goal_present,
                          out_res_q.chosen_end,
                          out_res_q.chosen_size};

endmodule

>>> src/tsrc_accum.sv
// Accumulator registers with merge, clear and direction register update.
module tsrc_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  tsrc_pkg::op_e  op_i,
  input  tsrc_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic           cfg_fwd_i,
  output logic           fwd_o,
  output tsrc_pkg::accum_t st_o,
  output tsrc_pkg::accum_t st_next_o
);
  import tsrc_pkg::*;

  logic   fwd_q, fwd_d;
  accum_t st_q, st_d;
  accum_t mrg;

  time_t inf, goal_in, goal_cur, os, oe, osl, oel, ns, ne;
  logic  ocan, s_mine, e_mine, s_theirs, e_theirs;

  // Merge one request into the held state
  always_comb begin
    inf      = dir_inf(fwd_q);
    goal_in  = req_i.goal_valid ? req_i.goal_value : inf;
    goal_cur = st_q.goal_held ? st_q.goal_best : inf;
    os       = req_i.size_valid ? req_i.size_value : inf;
    oe       = req_i.end_valid ? req_i.end_value : inf;
    ocan     = req_i.size_valid & req_i.end_valid;
    osl      = req_i.size_limit_valid ? req_i.size_limit_value : inf;
    oel      = req_i.end_limit_valid ? req_i.end_limit_value : inf;

    mrg = st_q;
    if (smaller(fwd_q, goal_in, goal_cur)) begin
      mrg.goal_held = req_i.goal_valid;
      mrg.goal_best = req_i.goal_valid ? req_i.goal_value : '0;
    end

    // Second best: the loser of the two firsts, or the old second if that is better
    if (smaller(fwd_q, st_q.size_best, os)) begin
      mrg.size_second = pick_min(fwd_q, st_q.size_second, os);
    end else if (smaller(fwd_q, os, st_q.size_best)) begin
      mrg.size_second = st_q.size_best;
    end
    if (smaller(fwd_q, st_q.end_best, oe)) begin
      mrg.end_second = pick_min(fwd_q, st_q.end_second, oe);
    end else if (smaller(fwd_q, oe, st_q.end_best)) begin
      mrg.end_second = st_q.end_best;
    end

    ns       = pick_min(fwd_q, st_q.size_best, os);
    ne       = pick_min(fwd_q, st_q.end_best, oe);
    s_mine   = (ns == st_q.size_best);
    e_mine   = (ne == st_q.end_best);
    s_theirs = (ns == os);
    e_theirs = (ne == oe);

    // Track whether best size and best end share one source
    if ((s_mine == e_mine) && (s_theirs == e_theirs)) begin
      if (s_mine) begin
        if (s_theirs) begin
          mrg.same_source = st_q.same_source & ocan;
        end
      end else begin
        mrg.same_source = s_theirs & ocan;
      end
    end else begin
      mrg.same_source = 1'b0;
    end

    mrg.size_best = ns;
    mrg.end_best  = ne;
    mrg.size_hard = pick_min(fwd_q, st_q.size_hard, osl);
    mrg.end_hard  = pick_min(fwd_q, st_q.end_hard, oel);
  end

  // Select next state; a register write clears under the new direction
  always_comb begin
    fwd_d = fwd_q;
    st_d  = st_q;
    if (cfg_we_i) begin
      fwd_d = cfg_fwd_i;
      st_d  = accum_clear(cfg_fwd_i);
    end else if (step_i) begin
      case (op_i)
        OP_MERGE: st_d = mrg;
        OP_CLEAR: st_d = accum_clear(fwd_q);
        default:  st_d = st_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b1;
      st_q  <= accum_clear(1'b1);
    end else begin
      fwd_q <= fwd_d;
      st_q  <= st_d;
    end
  end

  assign fwd_o     = fwd_q;
  assign st_o      = st_q;
  assign st_next_o = st_d;

endmodule

>>> src/tsrc_eval.sv
// Result logic: step query, hard limit check, bad request flag and goal report.
module tsrc_eval (
  input  logic             fwd_i,
  input  tsrc_pkg::op_e    op_i,
  input  tsrc_pkg::req_t   req_i,
  input  tsrc_pkg::accum_t st_i,
  input  tsrc_pkg::accum_t st_next_i,
  output tsrc_pkg::res_t   res_o
);
  import tsrc_pkg::*;

  time_t start, goal_sz, sfe, req_sz, m_sz, q_size;
  time_t goal_en, efs, req_en, m_en, q_end;
  logic  sz_blocked, en_blocked;

  // Query: chosen step size
  always_comb begin
    start      = req_i.start_time;
    goal_sz    = st_i.goal_held ? st_i.goal_best : req_i.goal_value;
    sfe        = minus_sat(fwd_i, st_i.end_best, start);
    req_sz     = pick_max(fwd_i, st_i.size_best, sfe);
    sz_blocked = smaller(fwd_i, goal_sz, req_sz) ||
                 smaller(fwd_i, st_i.size_second, req_sz) ||
                 smaller(fwd_i, minus_sat(fwd_i, st_i.end_second, start), req_sz);
    m_sz       = pick_min(fwd_i, pick_min(fwd_i, goal_sz, st_i.size_best), sfe);
    q_size     = (st_i.same_source && !sz_blocked) ? req_sz : m_sz;
  end

  // Query: chosen step end
  always_comb begin
    goal_en    = plus_sat(fwd_i, start, goal_sz);
    efs        = plus_sat(fwd_i, start, st_i.size_best);
    req_en     = pick_max(fwd_i, st_i.end_best, efs);
    en_blocked = smaller(fwd_i, goal_en, req_en) ||
                 smaller(fwd_i, plus_sat(fwd_i, start, st_i.size_second), req_en) ||
                 smaller(fwd_i, st_i.end_second, req_en);
    m_en       = pick_min(fwd_i, pick_min(fwd_i, goal_en, st_i.end_best), efs);
    q_end      = (st_i.same_source && !en_blocked) ? req_en : m_en;
  end

  // Assemble result fields per opcode
  always_comb begin
    res_o                     = '0;
    res_o.goal_present        = st_next_i.goal_held;
    res_o.goal_out            = st_next_i.goal_held ? st_next_i.goal_best : '0;
    case (op_i)
      OP_MERGE: begin
        res_o.bad_request = req_i.goal_valid & req_i.size_valid &
                            smaller(fwd_i, req_i.goal_value, req_i.size_value);
      end
      OP_QUERY: begin
        res_o.chosen_size = q_size;
        res_o.chosen_end  = q_end;
      end
      OP_CHECK: begin
        res_o.size_limit_violated = smaller(fwd_i, st_i.size_hard, req_i.size_value);
        res_o.end_limit_violated  = smaller(fwd_i, st_i.end_hard, req_i.end_value);
      end
      default: ;
    endcase
  end

endmodule

>>> tb/tb_time_step_request_combiner_top.sv
// Self-checking testbench for the time step request combiner: directed table, then random beats.
module tb_time_step_request_combiner_top;
  import tsrc_pkg::*;

  localparam time_t ONE        = 64'sd1 <<< 24;
  localparam int    PROBES     = 23;
  localparam int    PHASE_BEATS = 240;
  localparam int    CYCLE_LIMIT = 300000;

  // One request as the testbench sees it
  typedef struct packed {
    logic  goal_v;
    time_t goal;
    logic  step_v;
    time_t step_len;
    logic  stop_v;
    time_t stop_at;
    logic  lim_len_v;
    time_t lim_len;
    logic  lim_stop_v;
    time_t lim_stop;
    time_t start_at;
  } step_req_t;

  // One result beat, unpacked
  typedef struct packed {
    time_t len;
    time_t stop;
    logic  goal_p;
    time_t goal;
    logic  len_over;
    logic  stop_over;
    logic  bad;
  } step_answer_t;

  // One row of the directed table
  typedef struct packed {
    op_e          op;
    step_req_t    rq;
    logic         typed;
    step_answer_t want;
  } probe_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                s_valid    = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data     = '0;
  logic [OpW-1:0]      s_user     = '0;
  logic                m_valid;
  logic                m_ready    = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic                cfg_data   = 1'b0;

  // Mirror of the block's accumulator
  logic  pr_fwd = 1'b1;
  logic  goal_held;
  time_t goal_best;
  time_t len_best;
  time_t stop_best;
  logic  pair_src;
  time_t len_second;
  time_t stop_second;
  time_t len_hard;
  time_t stop_hard;

  step_answer_t answers_due[$];
  int           mismatches = 0;
  int           cycles     = 0;
  int           src_idle   = 0;
  int           sink_idle  = 0;
  logic         sink_hold  = 1'b0;
  time_t        start_ref  = '0;
  step_answer_t seen_ans;
  step_answer_t due_ans;

  time_step_request_combiner_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic time_t horizon();
    return pr_fwd ? TimeMax : TimeMin;
  endfunction

  // a lies before b in the direction of evolution
  function automatic logic ahead(time_t a, time_t b);
    return pr_fwd ? (a < b) : (a > b);
  endfunction

  function automatic time_t earliest(time_t a, time_t b);
    return ahead(b, a) ? b : a;
  endfunction

  function automatic time_t latest(time_t a, time_t b);
    return ahead(a, b) ? b : a;
  endfunction

  function automatic time_t clamp65(logic signed [64:0] w);
    if (w > TimeMax) return TimeMax;
    if (w < TimeMin) return TimeMin;
    return w[63:0];
  endfunction

  // start + x, keeping infinity in x
  function automatic time_t advance(time_t start, time_t x);
    if (x == horizon()) return x;
    return clamp65($signed({start[63], start}) + $signed({x[63], x}));
  endfunction

  // x - start, keeping infinity in x
  function automatic time_t span(time_t x, time_t start);
    if (x == horizon()) return x;
    return clamp65($signed({x[63], x}) - $signed({start[63], start}));
  endfunction

  function automatic void wipe_accum();
    goal_held   = 1'b0;
    goal_best   = '0;
    pair_src    = 1'b0;
    len_best    = horizon();
    stop_best   = horizon();
    len_second  = horizon();
    stop_second = horizon();
    len_hard    = horizon();
    stop_hard   = horizon();
  endfunction

  function automatic void absorb(step_req_t rq);
    time_t inf, os, oe, ns, ne;
    logic  both, s_old, e_old, s_new, e_new;
    inf  = horizon();
    os   = rq.step_v ? rq.step_len : inf;
    oe   = rq.stop_v ? rq.stop_at : inf;
    both = rq.step_v && rq.stop_v;
    // keep the earliest goal; a missing goal never wins
    if (rq.goal_v && ahead(rq.goal, goal_held ? goal_best : inf)) begin
      goal_held = 1'b1;
      goal_best = rq.goal;
    end
    // runner-up size and end
    if (ahead(len_best, os)) begin
      len_second = earliest(len_second, os);
    end else if (ahead(os, len_best)) begin
      len_second = len_best;
    end
    if (ahead(stop_best, oe)) begin
      stop_second = earliest(stop_second, oe);
    end else if (ahead(oe, stop_best)) begin
      stop_second = stop_best;
    end
    ns    = earliest(len_best, os);
    ne    = earliest(stop_best, oe);
    s_old = (ns == len_best);
    e_old = (ne == stop_best);
    s_new = (ns == os);
    e_new = (ne == oe);
    // track whether the best size and end come from one request
    if (s_old == e_old && s_new == e_new) begin
      if (s_old) begin
        if (s_new) pair_src = pair_src && both;
      end else begin
        pair_src = s_new ? both : 1'b0;
      end
    end else begin
      pair_src = 1'b0;
    end
    len_best  = ns;
    stop_best = ne;
    len_hard  = earliest(len_hard, rq.lim_len_v ? rq.lim_len : inf);
    stop_hard = earliest(stop_hard, rq.lim_stop_v ? rq.lim_stop : inf);
  endfunction

  function automatic time_t choose_len(time_t start, time_t fallback);
    time_t goal, sfe, req;
    goal = goal_held ? goal_best : fallback;
    sfe  = span(stop_best, start);
    // a paired request may stretch to the larger of its two limits
    if (pair_src) begin
      req = latest(len_best, sfe);
      if (!(ahead(goal, req) || ahead(len_second, req) ||
            ahead(span(stop_second, start), req)))
        return req;
    end
    return earliest(earliest(goal, len_best), sfe);
  endfunction

  function automatic time_t choose_stop(time_t start, time_t fallback);
    time_t goal, efs, req;
    goal = advance(start, goal_held ? goal_best : fallback);
    efs  = advance(start, len_best);
    if (pair_src) begin
      req = latest(stop_best, efs);
      if (!(ahead(goal, req) || ahead(advance(start, len_second), req) ||
            ahead(stop_second, req)))
        return req;
    end
    return earliest(earliest(goal, stop_best), efs);
  endfunction

  function automatic step_answer_t predict_step(op_e op, step_req_t rq);
    step_answer_t a;
    a = '0;
    case (op)
      OP_MERGE: begin
        a.bad = rq.goal_v && rq.step_v && ahead(rq.goal, rq.step_len);
        absorb(rq);
      end
      OP_QUERY: begin
        a.len  = choose_len(rq.start_at, rq.goal);
        a.stop = choose_stop(rq.start_at, rq.goal);
      end
      OP_CHECK: begin
        a.len_over  = ahead(len_hard, rq.step_len);
        a.stop_over = ahead(stop_hard, rq.stop_at);
      end
      default: begin
        wipe_accum();
      end
    endcase
    a.goal_p = goal_held;
    a.goal   = goal_held ? goal_best : '0;
    return a;
  endfunction

  // ---------------------------------------------------------------- packing

  function automatic logic [InDataW-1:0] pack_req(step_req_t r);
    return {3'b000, r.start_at, r.lim_stop, r.lim_stop_v, r.lim_len, r.lim_len_v,
            r.stop_at, r.stop_v, r.step_len, r.step_v, r.goal, r.goal_v};
  endfunction

  function automatic step_answer_t split_answer(logic [OutDataW-1:0] d);
    step_answer_t a;
    a.len       = d[63:0];
    a.stop      = d[127:64];
    a.goal_p    = d[128];
    a.goal      = d[192:129];
    a.len_over  = d[193];
    a.stop_over = d[194];
    a.bad       = d[195];
    return a;
  endfunction

  // ---------------------------------------------------------------- directed table

  function automatic step_req_t req(logic gv, time_t g, logic sv, time_t s, logic ev,
                                    time_t e, logic lv, time_t l, logic mv, time_t m,
                                    time_t st);
    step_req_t r;
    r.goal_v     = gv;
    r.goal       = g;
    r.step_v     = sv;
    r.step_len   = s;
    r.stop_v     = ev;
    r.stop_at    = e;
    r.lim_len_v  = lv;
    r.lim_len    = l;
    r.lim_stop_v = mv;
    r.lim_stop   = m;
    r.start_at   = st;
    return r;
  endfunction

  function automatic step_answer_t ans(time_t len, time_t stop, logic gp, time_t g,
                                       logic lo, logic so, logic bad);
    step_answer_t a;
    a.len       = len;
    a.stop      = stop;
    a.goal_p    = gp;
    a.goal      = g;
    a.len_over  = lo;
    a.stop_over = so;
    a.bad       = bad;
    return a;
  endfunction

  function automatic probe_row_t probe(int i);
    step_answer_t z;
    z = '0;
    case (i)
      // fallback goal alone decides a query after reset
      0:  return {OP_QUERY, req(0, 5*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                  ans(5*ONE, 5*ONE, 0, 0, 0, 0, 0)};
      // nothing lies past infinity
      1:  return {OP_CHECK, req(1, 0, 1, TimeMax, 1, TimeMax, 1, 0, 1, 0, 0), 1'b1, z};
      2:  return {OP_CHECK, req(0, 0, 0, TimeMin, 0, TimeMin, 0, 0, 0, 0, 0), 1'b1, z};
      // goal below its own size: flagged and merged anyway
      3:  return {OP_MERGE, req(1, ONE, 1, 2*ONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                  ans(0, 0, 1, ONE, 0, 0, 1)};
      // invalid parts are ignored, even extreme ones
      4:  return {OP_MERGE, req(0, TimeMin, 0, TimeMax, 0, TimeMax, 0, TimeMin, 0, TimeMin,
                  TimeMax), 1'b1, ans(0, 0, 1, ONE, 0, 0, 0)};
      5:  return {OP_MERGE, req(1, TimeMin, 1, TimeMax, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                  ans(0, 0, 1, TimeMin, 0, 0, 1)};
      6:  return {OP_CLEAR, req(1, ONE, 1, ONE, 1, ONE, 1, ONE, 1, ONE, ONE), 1'b1, z};
      7:  return {OP_MERGE, req(0, 0, 1, 10*ONE, 1, 100*ONE, 1, 50*ONE, 1, 200*ONE, 0),
                  1'b0, z};
      8:  return {OP_MERGE, req(0, 0, 1, 20*ONE, 1, 30*ONE, 0, 0, 0, 0, 0), 1'b0, z};
      9:  return {OP_QUERY, req(1, 1000*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, z};
      // saturating sums at both ends of the range
      10: return {OP_QUERY, req(0, TimeMax, 0, 0, 0, 0, 0, 0, 0, 0, TimeMax), 1'b0, z};
      11: return {OP_QUERY, req(0, 3*ONE, 1, 0, 1, 0, 1, 0, 1, 0, TimeMin), 1'b0, z};
      12: return {OP_CHECK, req(0, 0, 0, 60*ONE, 0, 250*ONE, 0, 0, 0, 0, 0), 1'b1,
                  ans(0, 0, 0, 0, 1, 1, 0)};
      13: return {OP_CHECK, req(0, 0, 0, 50*ONE, 0, 200*ONE, 0, 0, 0, 0, 0), 1'b1, z};
      14: return {OP_CLEAR, req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z};
      // size and end from one request, then a looser pair
      15: return {OP_MERGE, req(0, 0, 1, 10*ONE, 1, 10*ONE, 0, 0, 0, 0, 0), 1'b0, z};
      16: return {OP_MERGE, req(0, 0, 1, 40*ONE, 1, 80*ONE, 0, 0, 0, 0, 0), 1'b0, z};
      17: return {OP_QUERY, req(0, 100*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, z};
      18: return {OP_MERGE, req(1, TimeMax, 1, TimeMax, 1, TimeMax, 1, TimeMax, 1, TimeMax,
                  0), 1'b0, z};
      19: return {OP_MERGE, req(1, TimeMin, 1, TimeMin, 1, TimeMin, 1, TimeMin, 1, TimeMin,
                  0), 1'b0, z};
      20: return {OP_CHECK, req(0, 0, 0, TimeMin, 0, TimeMin, 0, 0, 0, 0, 0), 1'b0, z};
      21: return {OP_QUERY, req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, TimeMax), 1'b0, z};
      default: return {OP_CLEAR, req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z};
    endcase
  endfunction

  // ---------------------------------------------------------------- random values

  // small value on a coarse grid so that ties are common
  function automatic time_t grid_len();
    time_t v;
    v = time_t'($urandom_range(48)) <<< 22;
    if ($urandom_range(4) == 0) v = -v;
    return pr_fwd ? v : -v;
  endfunction

  function automatic time_t pick_time();
    case ($urandom_range(15))
      0:       return TimeMax;
      1:       return TimeMin;
      2, 3:    return {$urandom, $urandom};
      4:       return $urandom_range(1) ? TimeMax - $urandom_range(2)
                                        : TimeMin + $urandom_range(2);
      default: return grid_len();
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(input op_e op, input step_req_t rq, input logic typed,
                           input step_answer_t want);
    step_answer_t due;
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= pack_req(rq);
    s_user  <= op;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    due = predict_step(op, rq);
    answers_due.push_back(typed ? want : due);
  endtask

  task automatic random_beat();
    op_e       op;
    step_req_t rq;
    int        pick;
    pick          = $urandom_range(99);
    rq.goal_v     = ($urandom_range(99) < 35);
    rq.goal       = pick_time();
    rq.step_v     = ($urandom_range(3) != 0);
    rq.step_len   = pick_time();
    rq.stop_v     = ($urandom_range(3) != 0);
    rq.stop_at    = pick_time();
    rq.lim_len_v  = ($urandom_range(99) < 30);
    rq.lim_len    = pick_time();
    rq.lim_stop_v = ($urandom_range(99) < 30);
    rq.lim_stop   = pick_time();
    rq.start_at   = ($urandom_range(9) < 7) ? start_ref : pick_time();
    if (pick < 55) begin
      op = OP_MERGE;
      // well-formed request: end mostly follows from the size at the common start
      if ($urandom_range(1)) begin
        rq.step_v   = 1'b1;
        rq.stop_v   = 1'b1;
        rq.step_len = grid_len();
        rq.stop_at  = advance(start_ref, $urandom_range(2) ? rq.step_len : grid_len());
      end
    end else if (pick < 75) begin
      op = OP_QUERY;
    end else if (pick < 96) begin
      op = OP_CHECK;
      // probe right at the hard limits
      if ($urandom_range(2) == 0) begin
        rq.step_len = len_hard - 1 + $urandom_range(2);
        rq.stop_at  = stop_hard - 1 + $urandom_range(2);
      end
    end else begin
      op = OP_CLEAR;
    end
    send_beat(op, rq, 1'b0, '0);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    s_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_direction(input logic fwd);
    cfg_valid <= 1'b1;
    cfg_data  <= fwd;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pr_fwd = fwd;
    wipe_accum();
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    m_ready <= !sink_hold && ($urandom_range(99) >= sink_idle);
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 40)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("unexpected beat", m_data[63:0], '0);
      end else begin
        due_ans  = answers_due.pop_front();
        seen_ans = split_answer(m_data);
        if (seen_ans.len !== due_ans.len)
          note_mismatch("chosen_size", seen_ans.len, due_ans.len);
        if (seen_ans.stop !== due_ans.stop)
          note_mismatch("chosen_end", seen_ans.stop, due_ans.stop);
        if (seen_ans.goal_p !== due_ans.goal_p)
          note_mismatch("goal_present", seen_ans.goal_p, due_ans.goal_p);
        if (seen_ans.goal !== due_ans.goal)
          note_mismatch("goal_out", seen_ans.goal, due_ans.goal);
        if (seen_ans.len_over !== due_ans.len_over)
          note_mismatch("size_limit_violated", seen_ans.len_over, due_ans.len_over);
        if (seen_ans.stop_over !== due_ans.stop_over)
          note_mismatch("end_limit_violated", seen_ans.stop_over, due_ans.stop_over);
        if (seen_ans.bad !== due_ans.bad)
          note_mismatch("bad_request", seen_ans.bad, due_ans.bad);
      end
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    probe_row_t row;
    wipe_accum();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset direction
    sink_idle = 50;
    for (int i = 0; i < PROBES; i++) begin
      row = probe(i);
      send_beat(row.op, row.rq, row.typed, row.want);
    end

    // random phases: alternate direction, step through the idling modes
    for (int p = 0; p < 6; p++) begin
      settle();
      write_direction(p % 2 == 1);
      start_ref = grid_len() <<< $urandom_range(3);
      case (p / 2)
        0:       begin src_idle = 36; sink_idle = 84; end
        1:       begin src_idle = 84; sink_idle = 36; end
        default: begin src_idle = 0;  sink_idle = 0;  end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // hold the sender until the pipeline is empty
        if (p == 1 && i == PHASE_BEATS / 2) settle();
        // hold the receiver off long enough to back up the input
        if (p == 4 && i == 20) begin
          fork
            begin
              sink_hold <= 1'b1;
              repeat (300) @(posedge clk);
              sink_hold <= 1'b0;
            end
          join_none
        end
        random_beat();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> time_step_request_combiner_top.f
src/tsrc_pkg.sv
src/tsrc_accum.sv
src/tsrc_eval.sv
src/time_step_request_combiner_top.sv
tb/tb_time_step_request_combiner_top.sv
